// ===== hw/rtl/wsu_pkg.sv =====
// Shared types and constants for the window statistics unit.
`timescale 1ns / 1ps

package wsu_pkg;

  localparam int MaxSamples = 64;
  localparam int QueueDepth = 2;

  localparam int CntW  = 7;
  localparam int SumW  = 31;
  localparam int SqW   = 54;
  localparam int WsW   = 37;
  localparam int DivW  = 59;  // dividend / quotient width of the shared divider
  localparam int DvsW  = 21;  // divisor width
  localparam int RadW  = 48;  // square root radicand width
  localparam int RootW = RadW / 2;

  // Closed window handed from the accumulator to the back end
  typedef struct packed {
    logic [CntW-1:0]        n;
    logic signed [SumW-1:0] sum;
    logic [SqW-1:0]         sumsq;
    logic signed [WsW-1:0]  wsum;
    logic                   ovf;
  } win_t;

  typedef logic [DvsW-1:0] den_tbl_t [MaxSamples+1];

  // n*Sxx - Sx^2 = n^2 (n^2 - 1) / 12, evaluated at elaboration
  function automatic den_tbl_t make_den_tbl();
    den_tbl_t t;
    longint   k;
    for (int i = 0; i <= MaxSamples; i++) begin
      k = longint'(i);
      t[i] = DvsW'((k * k * (k * k - 1)) / 12);
    end
    return t;
  endfunction

  localparam den_tbl_t DenTbl = make_den_tbl();

endpackage

// ===== hw/rtl/window_statistics_unit.sv =====
// Top level of the window statistics unit.
`timescale 1ns / 1ps

// Samples (signed, 8 fractional bits) are accepted one per cycle and summed
// into count, sum, sum of squares and index-weighted sum; the transaction
// with tlast closes the window and queues it (two windows deep) for the back
// end, which emits one result per window: floor mean, floored population
// standard deviation and least-squares slope with 16 fractional bits (zero
// under two samples). Samples past 64 in a window are dropped and set the
// overflow bit. The back end is paced by the bit-serial divider, used in
// turn for mean, variance and slope, and by the square root; the input
// stalls only when two closed windows are already waiting.
module window_statistics_unit import wsu_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [23:0] s_axis_tdata_i,  // [23:0] sample
  input  logic        s_axis_tlast_i,
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [87:0] m_axis_tdata_o   // mean_value, std_dev, slope, sample_count, overflow
);

  logic push, pop, full, empty;
  win_t win_in, win_out;

  wsu_front u_front (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .valid_i  (s_axis_tvalid_i),
    .ready_o  (s_axis_tready_o),
    .sample_i (s_axis_tdata_i),
    .last_i   (s_axis_tlast_i),
    .full_i   (full),
    .push_o   (push),
    .win_o    (win_in)
  );

  wsu_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .din_i   (win_in),
    .pop_i   (pop),
    .dout_o  (win_out),
    .full_o  (full),
    .empty_o (empty)
  );

  wsu_back u_back (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .empty_i   (empty),
    .win_i     (win_out),
    .pop_o     (pop),
    .m_valid_o (m_axis_tvalid_o),
    .m_ready_i (m_axis_tready_i),
    .m_data_o  (m_axis_tdata_o)
  );

endmodule

// ===== hw/rtl/wsu_front.sv =====
// Sample accumulator: count, sum, sum of squares and index-weighted sum.
`timescale 1ns / 1ps

module wsu_front import wsu_pkg::*; (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   valid_i,
  output logic                   ready_o,
  input  logic signed [23:0]     sample_i,
  input  logic                   last_i,
  input  logic                   full_i,
  output logic                   push_o,
  output win_t                   win_o
);

  logic [CntW-1:0]        count_q, count_d;
  logic signed [SumW-1:0] sum_q, sum_d;
  logic [SqW-1:0]         sumsq_q, sumsq_d;
  logic signed [WsW-1:0]  wsum_q, wsum_d;
  logic                   ovf_q, ovf_d;
  logic                   accept;
  logic                   room;
  logic signed [47:0]     sq;
  logic signed [31:0]     wprod;

  assign ready_o = !full_i;
  assign accept  = valid_i && ready_o;
  assign room    = count_q < CntW'(MaxSamples);
  assign sq      = sample_i * sample_i;
  assign wprod   = $signed({1'b0, count_q}) * sample_i;

  always_comb begin
    count_d = count_q;
    sum_d   = sum_q;
    sumsq_d = sumsq_q;
    wsum_d  = wsum_q;
    ovf_d   = ovf_q;
    if (room) begin
      count_d = count_q + CntW'(1);
      sum_d   = sum_q + SumW'(sample_i);
      sumsq_d = sumsq_q + SqW'(unsigned'(sq));
      wsum_d  = wsum_q + WsW'(wprod);
    end else begin
      ovf_d = 1'b1;
    end
  end

  assign push_o      = accept && last_i;
  assign win_o.n     = count_d;
  assign win_o.sum   = sum_d;
  assign win_o.sumsq = sumsq_d;
  assign win_o.wsum  = wsum_d;
  assign win_o.ovf   = ovf_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
      sum_q   <= '0;
      sumsq_q <= '0;
      wsum_q  <= '0;
      ovf_q   <= 1'b0;
    end else if (accept) begin
      if (last_i) begin
        count_q <= '0;
        sum_q   <= '0;
        sumsq_q <= '0;
        wsum_q  <= '0;
        ovf_q   <= 1'b0;
      end else begin
        count_q <= count_d;
        sum_q   <= sum_d;
        sumsq_q <= sumsq_d;
        wsum_q  <= wsum_d;
        ovf_q   <= ovf_d;
      end
    end
  end

endmodule

// ===== hw/rtl/wsu_fifo.sv =====
// Short queue of closed windows between accumulator and back end.
`timescale 1ns / 1ps

module wsu_fifo import wsu_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  win_t din_i,
  input  logic pop_i,
  output win_t dout_o,
  output logic full_o,
  output logic empty_o
);

  localparam int PtrW = (QueueDepth > 1) ? $clog2(QueueDepth) : 1;
  localparam int CntQW = $clog2(QueueDepth + 1);

  win_t             mem_q [QueueDepth];
  logic [PtrW-1:0]  wr_q, rd_q;
  logic [CntQW-1:0] cnt_q;
  logic             do_push, do_pop;

  assign full_o  = cnt_q == CntQW'(QueueDepth);
  assign empty_o = cnt_q == '0;
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign dout_o  = mem_q[rd_q];

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_q] <= din_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (do_push) begin
        wr_q <= (wr_q == PtrW'(QueueDepth - 1)) ? '0 : wr_q + PtrW'(1);
      end
      if (do_pop) begin
        rd_q <= (rd_q == PtrW'(QueueDepth - 1)) ? '0 : rd_q + PtrW'(1);
      end
      if (do_push && !do_pop) begin
        cnt_q <= cnt_q + CntQW'(1);
      end else if (do_pop && !do_push) begin
        cnt_q <= cnt_q - CntQW'(1);
      end
    end
  end

endmodule

// ===== hw/rtl/wsu_div.sv =====
// Bit-serial restoring divider, one quotient bit per cycle.
`timescale 1ns / 1ps

module wsu_div import wsu_pkg::*; (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            start_i,
  input  logic [DivW-1:0] dividend_i,
  input  logic [DvsW-1:0] divisor_i,
  output logic            busy_o,
  output logic            done_o,
  output logic [DivW-1:0] quot_o,
  output logic            rem_nz_o
);

  localparam int StepW = $clog2(DivW);

  logic [DivW-1:0]  q_q;
  logic [DvsW:0]    rem_q;
  logic [DvsW-1:0]  dvs_q;
  logic [StepW-1:0] step_q;
  logic             busy_q, done_q;
  logic [DvsW:0]    trial;
  logic             fits;

  assign trial    = {rem_q[DvsW-1:0], q_q[DivW-1]};
  assign fits     = trial >= {1'b0, dvs_q};
  assign busy_o   = busy_q;
  assign done_o   = done_q;
  assign quot_o   = q_q;
  assign rem_nz_o = rem_q != '0;

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      q_q   <= dividend_i;
      rem_q <= '0;
      dvs_q <= divisor_i;
    end else if (busy_q) begin
      q_q   <= {q_q[DivW-2:0], fits};
      rem_q <= fits ? trial - {1'b0, dvs_q} : trial;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      step_q <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        step_q <= '0;
      end else if (busy_q) begin
        step_q <= step_q + StepW'(1);
        if (step_q == StepW'(DivW - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

endmodule

// ===== hw/rtl/wsu_sqrt.sv =====
// Digit-by-digit integer square root, one root bit per cycle.
`timescale 1ns / 1ps

module wsu_sqrt import wsu_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic [RadW-1:0]  rad_i,
  output logic             done_o,
  output logic [RootW-1:0] root_o
);

  localparam int StepW = $clog2(RootW);
  localparam int RemW  = RootW + 2;

  logic [RadW-1:0]  rad_q;
  logic [RemW-1:0]  rem_q;
  logic [RootW-1:0] root_q;
  logic [StepW-1:0] step_q;
  logic             busy_q, done_q;
  logic [RemW-1:0]  cur, trial;
  logic             fits;

  assign cur    = {rem_q[RemW-3:0], rad_q[RadW-1 -: 2]};
  assign trial  = {root_q, 2'b01};
  assign fits   = cur >= trial;
  assign done_o = done_q;
  assign root_o = root_q;

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rad_q  <= rad_i;
      rem_q  <= '0;
      root_q <= '0;
    end else if (busy_q) begin
      rad_q  <= {rad_q[RadW-3:0], 2'b00};
      rem_q  <= fits ? cur - trial : cur;
      root_q <= {root_q[RootW-2:0], fits};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      step_q <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        step_q <= '0;
      end else if (busy_q) begin
        step_q <= step_q + StepW'(1);
        if (step_q == StepW'(RootW - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

endmodule

// ===== hw/rtl/wsu_back.sv =====
// Back end: mean, standard deviation and slope of one closed window.
`timescale 1ns / 1ps

module wsu_back import wsu_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        empty_i,
  input  win_t        win_i,
  output logic        pop_o,
  output logic        m_valid_o,
  input  logic        m_ready_i,
  output logic [87:0] m_data_o
);

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_MUL   = 3'd1;
  localparam logic [2:0] ST_SUB   = 3'd2;
  localparam logic [2:0] ST_DMEAN = 3'd3;
  localparam logic [2:0] ST_DVAR  = 3'd4;
  localparam logic [2:0] ST_SQRT  = 3'd5;
  localparam logic [2:0] ST_DSLP  = 3'd6;
  localparam logic [2:0] ST_OUT   = 3'd7;

  localparam logic signed [60:0] SlopeHi = 61'sd4294967295;
  localparam logic signed [60:0] SlopeLo = -61'sd4294967296;

  logic [2:0]          state_q, state_d;
  win_t                rec_q;
  logic [10:0]         sx_q;
  logic [12:0]         nsq_q;
  logic [DvsW-1:0]     den_q;
  logic [60:0]         p_nq_q;
  logic [61:0]         p_ss_q;
  logic signed [43:0]  p_nw_q;
  logic signed [41:0]  p_xs_q;
  logic [DivW-1:0]     d_q;
  logic signed [44:0]  num_q;
  logic [23:0]         mean_q;
  logic [22:0]         sd_q;
  logic [32:0]         slope_q;
  logic                out_valid_q;
  logic [87:0]         out_data_q;

  logic                div_start, div_busy, div_done, div_rem_nz;
  logic [DivW-1:0]     div_dividend, div_quot;
  logic [DvsW-1:0]     div_divisor;
  logic                sq_start, sq_done;
  logic [RootW-1:0]    sq_root;
  logic [30:0]         abs_sum;
  logic [44:0]         abs_num;
  logic signed [31:0]  mean_full;
  logic signed [60:0]  slope_full;
  logic                out_free;

  wsu_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (div_dividend),
    .divisor_i  (div_divisor),
    .busy_o     (div_busy),
    .done_o     (div_done),
    .quot_o     (div_quot),
    .rem_nz_o   (div_rem_nz)
  );

  wsu_sqrt u_sqrt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (sq_start),
    .rad_i   (div_quot[RadW-1:0]),
    .done_o  (sq_done),
    .root_o  (sq_root)
  );

  assign abs_sum  = rec_q.sum[SumW-1] ? unsigned'(-rec_q.sum) : unsigned'(rec_q.sum);
  assign abs_num  = num_q[44] ? unsigned'(-num_q) : unsigned'(num_q);
  assign out_free = !out_valid_q || m_ready_i;
  assign pop_o    = (state_q == ST_IDLE) && !empty_i;

  // floor division: negative dividends round away from zero on a remainder
  always_comb begin
    if (rec_q.sum[SumW-1]) begin
      mean_full = -($signed({1'b0, div_quot[30:0]}) + 32'(div_rem_nz));
    end else begin
      mean_full = $signed({1'b0, div_quot[30:0]});
    end
    if (num_q[44]) begin
      slope_full = -($signed({2'b00, div_quot}) + 61'(div_rem_nz));
    end else begin
      slope_full = $signed({2'b00, div_quot});
    end
  end

  always_comb begin
    state_d      = state_q;
    div_start    = 1'b0;
    div_dividend = DivW'(abs_sum);
    div_divisor  = DvsW'(rec_q.n);
    sq_start     = 1'b0;
    case (state_q)
      ST_IDLE: begin
        if (!empty_i) begin
          state_d = ST_MUL;
        end
      end
      ST_MUL: begin
        state_d = ST_SUB;
      end
      ST_SUB: begin
        div_start = 1'b1;
        state_d   = ST_DMEAN;
      end
      ST_DMEAN: begin
        if (div_done) begin
          div_start    = 1'b1;
          div_dividend = d_q;
          div_divisor  = DvsW'(nsq_q);
          state_d      = ST_DVAR;
        end
      end
      ST_DVAR: begin
        if (div_done) begin
          sq_start = 1'b1;
          state_d  = ST_SQRT;
        end
      end
      ST_SQRT: begin
        if (sq_done) begin
          if (rec_q.n >= CntW'(2)) begin
            div_start    = 1'b1;
            div_dividend = DivW'({abs_num[43:0], 8'b0});
            div_divisor  = den_q;
            state_d      = ST_DSLP;
          end else begin
            state_d = ST_OUT;
          end
        end
      end
      ST_DSLP: begin
        if (div_done) begin
          state_d = ST_OUT;
        end
      end
      ST_OUT: begin
        if (out_free) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      rec_q <= win_i;
      sx_q  <= 11'((14'(win_i.n) * 14'(win_i.n - CntW'(1))) >> 1);
      nsq_q <= 13'(win_i.n) * 13'(win_i.n);
      den_q <= DenTbl[win_i.n];
    end
    if (state_q == ST_MUL) begin
      p_nq_q <= 61'(rec_q.n) * 61'(rec_q.sumsq);
      p_ss_q <= unsigned'(62'(rec_q.sum) * 62'(rec_q.sum));
      p_nw_q <= $signed({1'b0, rec_q.n}) * rec_q.wsum;
      p_xs_q <= $signed({1'b0, sx_q}) * rec_q.sum;
    end
    if (state_q == ST_SUB) begin
      d_q   <= DivW'(62'(p_nq_q) - p_ss_q);
      num_q <= 45'(p_nw_q) - 45'(p_xs_q);
    end
    if (state_q == ST_DMEAN && div_done) begin
      mean_q <= 24'(mean_full);
    end
    if (state_q == ST_SQRT && sq_done) begin
      sd_q <= sq_root[RootW-1] ? 23'h7FFFFF : sq_root[22:0];
      if (rec_q.n < CntW'(2)) begin
        slope_q <= '0;
      end
    end
    if (state_q == ST_DSLP && div_done) begin
      if (slope_full > SlopeHi) begin
        slope_q <= 33'(SlopeHi);
      end else if (slope_full < SlopeLo) begin
        slope_q <= 33'(SlopeLo);
      end else begin
        slope_q <= 33'(slope_full);
      end
    end
    if (state_q == ST_OUT && out_free) begin
      out_data_q <= {rec_q.ovf, rec_q.n, slope_q, sd_q, mean_q};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (state_q == ST_OUT && out_free) begin
        out_valid_q <= 1'b1;
      end else if (m_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign m_valid_o = out_valid_q;
  assign m_data_o  = out_data_q;

  a_div_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_start |-> !div_busy)
    else $error("divider restarted while busy");

  a_sqrt_state: assert property (@(posedge clk_i) disable iff (!rst_ni)
    sq_done |-> state_q == ST_SQRT)
    else $error("square root finished outside its state");

  a_slope_short: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_valid_o && m_data_o[86:80] < 7'd2) |-> m_data_o[79:47] == 33'd0)
    else $error("nonzero slope for a window under two samples");

endmodule
